// File: sv/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// Constants, types and small functions shared by the hash core and its
// digit-serial multiplier.
// ----------------------------------------------------------------------------
package mm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned MulSteps   = WordWidth / DigitWidth;
   localparam int unsigned StepWidth  = $clog2(MulSteps);

   localparam logic [WordWidth-1:0] MixC1   = 32'hcc9e2d51;
   localparam logic [WordWidth-1:0] MixC2   = 32'h1b873593;
   localparam logic [WordWidth-1:0] FmixC3  = 32'h85ebca6b;
   localparam logic [WordWidth-1:0] FmixC4  = 32'hc2b2ae35;
   localparam logic [WordWidth-1:0] BlockC5 = 32'he6546b64;

   localparam int unsigned KeyRot   = 15;
   localparam int unsigned HashRot  = 13;
   localparam int unsigned FmixSh1  = 16;
   localparam int unsigned FmixSh2  = 13;
   localparam logic [2:0]  FullBytes = 3'd4;

   typedef struct packed {
      logic                 start;
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [WordWidth-1:0] product;
   } mul_rsp_type;

   function automatic logic [WordWidth-1:0] rotl15(input logic [WordWidth-1:0] x);
      rotl15 = {x[WordWidth-1-KeyRot:0], x[WordWidth-1:WordWidth-KeyRot]};
   endfunction

   function automatic logic [WordWidth-1:0] rotl13(input logic [WordWidth-1:0] x);
      rotl13 = {x[WordWidth-1-HashRot:0], x[WordWidth-1:WordWidth-HashRot]};
   endfunction

endpackage

// File: sv/mm3_mul.sv
// ----------------------------------------------------------------------------
// mm3_mul
// Digit-serial multiplier, product modulo 2^32. The multiplicand shifts up
// and the multiplier shifts down by one digit each cycle.
// ----------------------------------------------------------------------------
module mm3_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mm3_pkg::mul_req_type req,
   output mm3_pkg::mul_rsp_type rsp
);

   logic [mm3_pkg::WordWidth-1:0] mcand_ff, mcand_in;
   logic [mm3_pkg::WordWidth-1:0] mplier_ff, mplier_in;
   logic [mm3_pkg::WordWidth-1:0] acc_ff, acc_in;
   logic [mm3_pkg::StepWidth-1:0] step_ff, step_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [mm3_pkg::WordWidth-1:0] partial;

   assign partial = mcand_ff *
      {{(mm3_pkg::WordWidth-mm3_pkg::DigitWidth){1'b0}},
       mplier_ff[mm3_pkg::DigitWidth-1:0]};

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (req.start) begin
         mcand_in  = req.a;
         mplier_in = req.b;
         acc_in    = '0;
         step_in   = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         acc_in    = acc_ff + partial;
         mcand_in  = mcand_ff << mm3_pkg::DigitWidth;
         mplier_in = mplier_ff >> mm3_pkg::DigitWidth;
         step_in   = step_ff + 1'b1;
         if (step_ff == mm3_pkg::StepWidth'(mm3_pkg::MulSteps - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// File: sv/murmur3_32_hash.sv
// ----------------------------------------------------------------------------
// murmur3_32_hash
// 32-bit MurmurHash3 (x86_32, seed 0) over a stream of little-endian words.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_word, req_byte_count, req_last
//   rsp      out        rsp_valid, rsp_stall, rsp_hash
//
// A word with bytes is multiplied by C1, then by C2, before the next acceptance;
// an empty word needs no product. A last word adds finalization by C3 and C4
// before the hash is loaded into the output register. All these products come
// from the single shared multiplier, which retires 4 bits of its constant per cycle.
// Synchronous reset clears the running hash, the length and the control.
// A stalled result blocks the loading of the next hash, and with it new words.
// ----------------------------------------------------------------------------
module murmur3_32_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash
);

   typedef enum logic [2:0] {
      IDLE,
      KEY_C1,
      KEY_C2,
      FIN_C3,
      FIN_C4,
      EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [31:0]          hash_ff, hash_in;
   logic [31:0]          length_ff, length_in;
   logic                 full_ff, full_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_hash_ff, rsp_hash_in;
   mm3_pkg::mul_req_type mul_req;
   mm3_pkg::mul_rsp_type mul_rsp;

   logic [2:0]  count_sat;
   logic [31:0] word_masked;
   logic [31:0] length_next;
   logic [31:0] hash_mixed;
   logic [31:0] fin_seed;
   logic [31:0] prod;
   logic        accept;
   logic        out_free;

   mm3_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign prod     = mul_rsp.product;
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_sat = req_byte_count[2] ? mm3_pkg::FullBytes : req_byte_count;
      case (count_sat)
         3'd1:    word_masked = {24'h0, req_word[7:0]};
         3'd2:    word_masked = {16'h0, req_word[15:0]};
         3'd3:    word_masked = {8'h0, req_word[23:0]};
         default: word_masked = req_word;
      endcase
      length_next = length_ff + {29'h0, count_sat};
      hash_mixed  = hash_ff ^ prod;
      if (full_ff) begin
         hash_mixed = mm3_pkg::rotl13(hash_mixed);
         hash_mixed = hash_mixed + {hash_mixed[29:0], 2'b00} + mm3_pkg::BlockC5;
      end
      fin_seed = (state_ff == IDLE) ? (hash_ff ^ length_ff) : (hash_mixed ^ length_ff);
      fin_seed = fin_seed ^ (fin_seed >> mm3_pkg::FmixSh1);
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      length_in    = length_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_req      = '{start: 1'b0, a: prod, b: mm3_pkg::MixC2};
      case (state_ff)
         IDLE: begin
            if (accept) begin
               length_in = length_next;
               full_in   = (count_sat == mm3_pkg::FullBytes);
               last_in   = req_last;
               if (count_sat != 3'd0) begin
                  mul_req  = '{start: 1'b1, a: word_masked, b: mm3_pkg::MixC1};
                  state_in = KEY_C1;
               end else if (req_last) begin
                  mul_req  = '{start: 1'b1, a: fin_seed, b: mm3_pkg::FmixC3};
                  state_in = FIN_C3;
               end
            end
         end
         KEY_C1: begin
            if (mul_rsp.done) begin
               mul_req  = '{start: 1'b1, a: mm3_pkg::rotl15(prod), b: mm3_pkg::MixC2};
               state_in = KEY_C2;
            end
         end
         KEY_C2: begin
            if (mul_rsp.done) begin
               hash_in = hash_mixed;
               if (last_ff) begin
                  mul_req  = '{start: 1'b1, a: fin_seed, b: mm3_pkg::FmixC3};
                  state_in = FIN_C3;
               end else begin
                  state_in = IDLE;
               end
            end
         end
         FIN_C3: begin
            if (mul_rsp.done) begin
               mul_req  = '{start: 1'b1, a: prod ^ (prod >> mm3_pkg::FmixSh2),
                            b: mm3_pkg::FmixC4};
               state_in = FIN_C4;
            end
         end
         FIN_C4: begin
            if (mul_rsp.done) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (out_free) begin
               rsp_hash_in  = prod ^ (prod >> mm3_pkg::FmixSh1);
               rsp_valid_in = 1'b1;
               hash_in      = '0;
               length_in    = '0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      full_ff     <= full_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         state_ff     <= IDLE;
         hash_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

endmodule

// File: test/murmur3_32_hash_check.sv
// ----------------------------------------------------------------------------
// murmur3_32_hash_check
// Watches both channels of the hash core, keeps its own running hash and byte
// length, and predicts the finalized hash of every message that ends on an
// accepted last word. Each accepted hash is compared with the oldest
// prediction, and the failures are counted for the top level.
// ----------------------------------------------------------------------------
module murmur3_32_hash_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_hash,
   output int unsigned error_count,
   output int unsigned hashes_pending,
   output int unsigned hashes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] running_hash;
   logic [31:0] running_length;
   logic [31:0] expected_hashes[$];
   int unsigned errors = 0;
   int unsigned checked = 0;

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_key(input logic [31:0] k);
      logic [31:0] t;
      t = k * mm3_pkg::MixC1;
      t = rotate_left(t, mm3_pkg::KeyRot);
      t = t * mm3_pkg::MixC2;
      return t;
   endfunction

   function automatic logic [31:0] fmix32(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> mm3_pkg::FmixSh1);
      t = t * mm3_pkg::FmixC3;
      t = t ^ (t >> mm3_pkg::FmixSh2);
      t = t * mm3_pkg::FmixC4;
      t = t ^ (t >> mm3_pkg::FmixSh1);
      return t;
   endfunction

   always @(posedge clock) begin
      logic [2:0]  bytes;
      logic [31:0] expected;
      if (reset) begin
         running_hash   = '0;
         running_length = '0;
         expected_hashes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: hash %08h arrived with none expected", $time, rsp_hash);
               errors++;
            end else begin
               expected = expected_hashes.pop_front();
               checked++;
               if (rsp_hash !== expected) begin
                  $display("%0t: hash mismatch, expected %08h, got %08h",
                           $time, expected, rsp_hash);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes = (req_byte_count > mm3_pkg::FullBytes) ? mm3_pkg::FullBytes
                                                          : req_byte_count;
            if (bytes == mm3_pkg::FullBytes) begin
               running_hash = running_hash ^ scramble_key(req_word);
               running_hash = rotate_left(running_hash, mm3_pkg::HashRot);
               running_hash = running_hash * 32'd5 + mm3_pkg::BlockC5;
            end else if (bytes != 3'd0) begin
               running_hash = running_hash ^
                              scramble_key(req_word & ((32'd1 << (8 * bytes)) - 32'd1));
            end
            running_length = running_length + 32'(bytes);
            if (req_last) begin
               expected_hashes.push_back(fmix32(running_hash ^ running_length));
               running_hash   = '0;
               running_length = '0;
            end
         end
      end
      error_count    <= errors;
      hashes_pending <= expected_hashes.size();
      hashes_checked <= checked;
   end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the hash core with a short directed set of messages and then with
// random messages and noise words, under bursty input and random output
// stalls. A checker beside the core predicts every hash and counts failures.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WordTarget = 1550;
   localparam int unsigned CycleLimit = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_hash;

   int unsigned error_count;
   int unsigned hashes_pending;
   int unsigned hashes_checked;
   int unsigned words_sent = 0;
   int unsigned messages_sent = 0;
   int unsigned burst_left = 0;
   int unsigned stall_run = 0;
   int unsigned stall_mode = 0;
   int unsigned cycles = 0;

   murmur3_32_hash dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash       (rsp_hash)
   );

   murmur3_32_hash_check check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash       (rsp_hash),
      .error_count    (error_count),
      .hashes_pending (hashes_pending),
      .hashes_checked (hashes_checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 64);
         end
         stall_run--;
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_stall <= 1'b1;
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Timed out after %0d cycles with %0d hashes outstanding.",
                     cycles, hashes_pending);
            $display("FAIL murmur3_32_hash");
            $finish;
         end
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic fin);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_word       <= w;
      req_byte_count <= n;
      req_last       <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (fin) messages_sent++;
   endtask

   initial begin
      int unsigned full_words;
      int unsigned noise_words;
      logic [2:0]  n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(32'h0000_0000, 3'd0, 1'b1);
      send_word(32'hffff_ffab, 3'd1, 1'b1);
      send_word(32'h1234_5678, 3'd2, 1'b1);
      send_word(32'hffff_ffff, 3'd3, 1'b1);
      send_word(32'h0000_0000, 3'd4, 1'b1);
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'h89ab_cdef, 3'd5, 1'b1);
      send_word(32'h0f0f_0f0f, 3'd6, 1'b0);
      send_word(32'hf0f0_f0f0, 3'd7, 1'b1);
      send_word(32'h0302_0100, 3'd4, 1'b0);
      send_word(32'h0706_0504, 3'd4, 1'b0);
      send_word(32'hff0a_0908, 3'd3, 1'b1);
      send_word(32'hdead_beef, 3'd2, 1'b0);
      send_word(32'h1122_3344, 3'd4, 1'b0);
      send_word(32'hcafe_f00d, 3'd0, 1'b0);
      send_word(32'hffff_ff55, 3'd1, 1'b1);
      send_word(32'h5555_5555, 3'd0, 1'b0);
      send_word(32'haaaa_aaaa, 3'd0, 1'b1);

      while (words_sent < WordTarget) begin
         if ($urandom_range(0, 9) < 8) begin
            full_words = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(0, 5);
            repeat (full_words) begin
               n = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
               send_word(random_word(), n, 1'b0);
            end
            n = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
            send_word(random_word(), n, 1'b1);
         end else begin
            noise_words = $urandom_range(1, 6);
            repeat (noise_words - 1) begin
               send_word(random_word(), 3'($urandom_range(0, 7)), 1'b0);
            end
            send_word(random_word(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (hashes_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d words making up %0d finished messages, under bursty input",
               words_sent, messages_sent);
      $display("and random output stalls; %0d hashes were compared.", hashes_checked);
      if (error_count == 0 && hashes_pending == 0) begin
         $display("PASS murmur3_32_hash");
      end else begin
         $display("%0d failures, %0d hashes never arrived.", error_count, hashes_pending);
         $display("FAIL murmur3_32_hash");
      end
      $finish;
   end

endmodule

// File: murmur3_32_hash.f
sv/mm3_pkg.sv
sv/mm3_mul.sv
sv/murmur3_32_hash.sv
test/murmur3_32_hash_check.sv
test/tb.sv
